// ===== design/mts_pkg.sv =====
// shared types and codes for the min tracking stack
package mts_pkg;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } status_t;

  typedef enum logic {
    KIND_PUSH = 1'b0,
    KIND_POP  = 1'b1
  } kind_t;

  typedef enum logic {
    S_IDLE  = 1'b0,
    S_FETCH = 1'b1
  } state_t;

  localparam int DATA_W  = 32;
  localparam int DEPTH_W = 11;

endpackage

// ===== design/mts_ram.sv =====
// generic simple dual port ram with registered read
module mts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/min_tracking_stack.sv =====
// min tracking stack top level: value and minimum stacks in two rams
//
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------
//  in      | in_valid, in_ready  | kind, value
//  out     | out_valid, out_ready| top_value, min_value, depth, status
//
// a push or a rejected operation is answered straight from idle; a successful pop
// goes through the fetch state, since the rams return the new tops from a registered read.
// top and minimum are kept in registers so a push never reads the rams.
// reset clears both counts; ram contents are left as they are.
// a new word is taken in the idle state while the result register is empty or being drained.
module min_tracking_stack #(
  parameter int STACK_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               kind,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] top_value,
  output logic signed [31:0] min_value,
  output logic [10:0]        depth,
  output logic [1:0]         status
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  mts_pkg::state_t  state, state_next;
  mts_pkg::status_t status_reg;

  logic [CW-1:0] value_count, min_count;
  logic [31:0]   top_reg, min_reg;
  logic          reload_top, reload_min;

  logic          accept, is_pop, full, min_take, pop_min, pop_ok;
  logic [CW-1:0] vc_m2, mc_m2;
  logic [31:0]   v_rdata, m_rdata;
  logic          v_we, m_we;

  assign accept   = in_valid && in_ready;
  assign is_pop   = (kind == mts_pkg::KIND_POP);
  assign full     = (value_count == CW'(STACK_DEPTH));
  assign min_take = (min_count == '0) || ($signed(value) <= $signed(min_reg));
  assign pop_min  = (min_count != '0) && (min_reg == top_reg);
  assign pop_ok   = accept && is_pop && (value_count != '0);
  assign vc_m2    = value_count - CW'(2);
  assign mc_m2    = min_count - CW'(2);
  assign v_we     = accept && !is_pop && !full;
  assign m_we     = v_we && min_take;

  mts_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_value_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (value_count[AW-1:0]),
    .wdata (value),
    .raddr (vc_m2[AW-1:0]),
    .rdata (v_rdata)
  );

  mts_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_min_ram (
    .clk   (clk),
    .we    (m_we),
    .waddr (min_count[AW-1:0]),
    .wdata (value),
    .raddr (mc_m2[AW-1:0]),
    .rdata (m_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mts_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    case (state)
      mts_pkg::S_IDLE: begin
        in_ready = !out_valid || out_ready;
        if (pop_ok) begin
          state_next = mts_pkg::S_FETCH;
        end
      end
      mts_pkg::S_FETCH: begin
        state_next = mts_pkg::S_IDLE;
      end
      default: begin
        state_next = mts_pkg::S_IDLE;
      end
    endcase
  end

  // counts and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      value_count <= '0;
      min_count   <= '0;
      out_valid   <= 1'b0;
    end else begin
      if ((accept && !pop_ok) || (state == mts_pkg::S_FETCH)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (v_we) begin
        value_count <= value_count + CW'(1);
        if (min_take) begin
          min_count <= min_count + CW'(1);
        end
      end
      if (pop_ok) begin
        value_count <= value_count - CW'(1);
        if (pop_min) begin
          min_count <= min_count - CW'(1);
        end
      end
    end
  end

  // cached tops and status
  always_ff @(posedge clk) begin
    if (accept) begin
      if (is_pop) begin
        status_reg <= (value_count == '0) ? mts_pkg::ST_POP_EMPTY : mts_pkg::ST_OK;
        reload_top <= (value_count > CW'(1));
        reload_min <= pop_min && (min_count > CW'(1));
      end else if (full) begin
        status_reg <= mts_pkg::ST_PUSH_FULL;
      end else begin
        status_reg <= mts_pkg::ST_OK;
        top_reg    <= value;
        if (min_take) begin
          min_reg <= value;
        end
      end
    end
    if (state == mts_pkg::S_FETCH) begin
      if (reload_top) begin
        top_reg <= v_rdata;
      end
      if (reload_min) begin
        min_reg <= m_rdata;
      end
    end
  end

  assign top_value = (value_count == '0) ? 32'sd0 : $signed(top_reg);
  assign min_value = (min_count == '0) ? 32'sd0 : $signed(min_reg);
  assign depth     = 11'(value_count);
  assign status    = status_reg;

endmodule
